@@ hdl/diagonal_edge_filter_3x3_assert.svh @@
// assertion macros for the diagonal edge filter
`ifndef DIAGONAL_EDGE_FILTER_3X3_ASSERT_SVH
`define DIAGONAL_EDGE_FILTER_3X3_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DEF3_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DEF3_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DEF3_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define DEF3_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/def3_pkg.sv @@
// shared types and constants of the diagonal edge filter
package def3_pkg;
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 12;
	localparam int OCOL_W     = 11;
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 12;
	localparam int OUT_DEPTH  = 3;

	localparam logic [REG_DATA_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [REG_DATA_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [ROW_W-1:0]      MIN_SIZE     = 12'd3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_DIRECTION    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0]  edge_value;
		logic [ROW_W-1:0]  out_row;
		logic [OCOL_W-1:0] out_col;
		logic              frame_done;
	} result_t;
endpackage

@@ hdl/def3_in_if.sv @@
// pixel input channel
interface def3_in_if;
	import def3_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

@@ hdl/def3_out_if.sv @@
// result output channel
interface def3_out_if;
	import def3_pkg::*;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  edge_value;
	logic [ROW_W-1:0]  out_row;
	logic [OCOL_W-1:0] out_col;
	logic              frame_done;

	modport source (output valid, output edge_value, output out_row, output out_col,
		output frame_done, input ready);
	modport sink (input valid, input edge_value, input out_row, input out_col,
		input frame_done, output ready);
endinterface

@@ hdl/def3_line_ram.sv @@
// line store memory, one write and one registered read port
module def3_line_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/def3_out_fifo.sv @@
// three-entry output buffer between the filter stage and the result channel
module def3_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  def3_pkg::result_t push_data,
	output logic [1:0]        level,
	def3_out_if.source        results
);
	import def3_pkg::*;

	result_t    mem_q [OUT_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] level_q;
	logic       pop;

	assign pop   = results.valid && results.ready;
	assign level = level_q;

	assign results.valid      = level_q != 2'd0;
	assign results.edge_value = mem_q[rd_ptr_q].edge_value;
	assign results.out_row    = mem_q[rd_ptr_q].out_row;
	assign results.out_col    = mem_q[rd_ptr_q].out_col;
	assign results.frame_done = mem_q[rd_ptr_q].frame_done;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(OUT_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(OUT_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			level_q <= level_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ hdl/diagonal_edge_filter_3x3.sv @@
// diagonal edge filter top level: position tracking, line store access, kernel sum
// a result passes the filter stage register and the output buffer before it is offered
// throughput: one pixel per cycle while the output buffer has room
// the line store is one memory holding both previous rows; a repeated column is forwarded
// reset clears position, window, pipeline and buffer state; line stores are not cleared
// registers reset to width 640, height 480, positive kernel
module diagonal_edge_filter_3x3 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	def3_in_if.sink                            pixels,
	def3_out_if.source                         results,
	input  logic                               wr_en,
	input  logic [def3_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [def3_pkg::REG_DATA_W-1:0]    wr_data
);
	import def3_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW0 = $clog2(MAX_WIDTH + 1);
	localparam int WW  = (WW0 > REG_DATA_W) ? WW0 : REG_DATA_W;
	localparam int XW  = (CW > OCOL_W) ? CW : OCOL_W;

	// configuration
	logic [REG_DATA_W-1:0] width_q;
	logic [REG_DATA_W-1:0] height_q;
	logic                  dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			dir_q    <= 1'b0;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_IMAGE_WIDTH:  width_q  <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				REG_DIRECTION:    dir_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]    wu;
	logic [ROW_W-1:0] hu;
	logic [WW-1:0]    width_ext;

	assign width_ext = WW'(width_q);
	assign hu = (height_q < MIN_SIZE) ? MIN_SIZE : height_q;

	always_comb begin
		if (width_ext < WW'(MIN_SIZE)) begin
			wu = WW'(MIN_SIZE);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			wu = WW'(MAX_WIDTH);
		end else begin
			wu = width_ext;
		end
	end

	// position of the incoming pixel
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_base;
	logic [ROW_W-1:0] row_base;
	logic [ROW_W:0]   row_pre;
	logic [CW-1:0]    cur_c;
	logic [ROW_W-1:0] cur_r;
	logic [ROW_W:0]   r_inc;
	logic             col_wrap;
	logic             col_end;
	logic             row_end;
	logic [CW-1:0]    col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic             emit;
	logic             last;
	logic [XW-1:0]    col_m1;
	logic             accept;
	logic [1:0]       level;
	logic             v_s1;

	assign col_base = pixels.frame_start ? '0 : col_q;
	assign row_base = pixels.frame_start ? '0 : row_q;
	assign col_wrap = WW'(col_base) >= wu;
	assign row_pre  = col_wrap ? {1'b0, row_base} + 13'd1 : {1'b0, row_base};
	assign cur_c    = col_wrap ? '0 : col_base;
	assign cur_r    = (row_pre >= {1'b0, hu}) ? '0 : row_pre[ROW_W-1:0];

	assign r_inc   = {1'b0, cur_r} + 13'd1;
	assign col_end = (WW'(cur_c) + WW'(1)) >= wu;
	assign row_end = r_inc >= {1'b0, hu};
	assign col_nxt = col_end ? '0 : cur_c + CW'(1);
	assign row_nxt = col_end ? (row_end ? '0 : r_inc[ROW_W-1:0]) : cur_r;

	assign emit   = (cur_r >= 12'd2) && (WW'(cur_c) >= WW'(2));
	assign last   = (cur_r == hu - 12'd1) && (WW'(cur_c) == wu - WW'(1));
	assign col_m1 = XW'(cur_c) - XW'(1);

	// one beat in flight in the filter stage plus the buffer never exceeds its depth
	assign pixels.ready = (3'(level) + 3'(v_s1)) < 3'(OUT_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// filter stage
	logic [CW-1:0]       addr_s1;
	logic [PIX_W-1:0]    px_s1;
	logic                emit_s1;
	logic                last_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [OCOL_W-1:0]   col_s1;
	logic                fwd_s1;
	logic [PIX_W-1:0]    fwd_top_s1;
	logic [PIX_W-1:0]    fwd_mid_s1;
	logic [2*PIX_W-1:0]  rd_data;
	logic [PIX_W-1:0]    top_eff;
	logic [PIX_W-1:0]    mid_eff;
	logic [PIX_W-1:0]    sum;
	logic [PIX_W-1:0]    win0_q, win1_q, win3_q, win4_q, win5_q;
	result_t             res;

	def3_line_ram #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW),
		.DW   (2 * PIX_W)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(addr_s1),
		.wdata({mid_eff, px_s1}),
		.re   (accept),
		.raddr(cur_c),
		.rdata(rd_data)
	);

	// same column written by the stage ahead while it was read
	assign top_eff = fwd_s1 ? fwd_top_s1 : rd_data[2*PIX_W-1:PIX_W];
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : rd_data[PIX_W-1:0];

	assign sum = win0_q + win3_q + win1_q - mid_eff - win5_q - px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= cur_c;
			px_s1      <= pixels.pixel;
			emit_s1    <= emit;
			last_s1    <= last;
			row_s1     <= cur_r - 12'd1;
			col_s1     <= col_m1[OCOL_W-1:0];
			fwd_s1     <= v_s1 && (addr_s1 == cur_c);
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
			win3_q <= '0;
			win4_q <= '0;
			win5_q <= '0;
		end else if (v_s1) begin
			win0_q <= win3_q;
			win1_q <= win4_q;
			win3_q <= top_eff;
			win4_q <= mid_eff;
			win5_q <= px_s1;
		end
	end

	assign res.edge_value = dir_q ? (PIX_W'(0) - sum) : sum;
	assign res.out_row    = row_s1;
	assign res.out_col    = col_s1;
	assign res.frame_done = last_s1;

	def3_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s1 && emit_s1),
		.push_data(res),
		.level    (level),
		.results  (results)
	);

`include "diagonal_edge_filter_3x3_assert.svh"

	`DEF3_ASSERT_NEXT(a_accept_enters_stage, clk, arst_n, accept, v_s1, "accepted beat lost")
	`DEF3_ASSERT_SAME(a_done_is_interior, clk, arst_n, v_s1 && last_s1, emit_s1, "frame end on border")
	`DEF3_ASSERT_NEXT(a_result_buffered, clk, arst_n, v_s1 && emit_s1, results.valid, "result dropped")
endmodule

@@ dv/tb_diagonal_edge_filter_3x3.sv @@
// testbench for the diagonal edge filter: directed frame table, random frames, scoreboard
`timescale 1ns / 100ps

module tb_diagonal_edge_filter_3x3;
	import def3_pkg::*;

	localparam int MAX_W        = 2048;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_GAP   = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 650;
	localparam int WIDE_ITEMS   = 150;
	localparam int PRINT_CAP    = 60;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		bit                    is_cfg;
		logic [REG_IDX_W-1:0]  idx;
		logic [REG_DATA_W-1:0] data;
		logic [PIX_W-1:0]      px;
		logic                  fs;
		bit                    typed;
		result_t               want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [REG_IDX_W-1:0]  wr_index;
	logic [REG_DATA_W-1:0] wr_data;

	def3_in_if  pix_if ();
	def3_out_if res_if ();

	diagonal_edge_filter_3x3 #(.MAX_WIDTH(MAX_W)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pix_if),
		.results  (res_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// predictor state
	logic [PIX_W-1:0]      upper_line [MAX_W];
	logic [PIX_W-1:0]      middle_line [MAX_W];
	logic [PIX_W-1:0]      win [6];
	logic [1:0]            col_hits [MAX_W];
	int                    row_pos;
	int                    col_pos;
	logic [REG_DATA_W-1:0] cfg_width;
	logic [REG_DATA_W-1:0] cfg_height;
	logic                  cfg_dir;

	result_t     pending_edges [$];
	script_row_t script [$];
	int          err_count;
	int          sent_count;
	int          cycle_count;
	bit          src_idle_on;
	bit          snk_idle_on;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic log_mismatch(input string msg);
		if (err_count < PRINT_CAP)
			$display("%0t ns: %s", $time, msg);
		err_count++;
	endtask

	function automatic int used_width();
		int v;
		v = cfg_width;
		if (v < MIN_SIZE) v = MIN_SIZE;
		if (v > MAX_W) v = MAX_W;
		return v;
	endfunction

	function automatic int used_height();
		int v;
		v = cfg_height;
		if (v < MIN_SIZE) v = MIN_SIZE;
		return v;
	endfunction

	// both line stores hold written data in every column below w
	function automatic bit all_defined(input int w);
		for (int i = 0; i < w; i++)
			if (col_hits[i] < 2) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit diag_kernel_step(input logic [PIX_W-1:0] px, input logic fs,
		output result_t res);
		int               w;
		int               h;
		int               r;
		int               c;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] acc;
		bit               hit;
		w = used_width();
		h = used_height();
		if (fs) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		r = row_pos;
		c = col_pos;
		top = upper_line[c];
		mid = middle_line[c];
		hit = (r >= 2 && c >= 2);
		res = '0;
		if (hit) begin
			// top-left, top-mid, mid-left minus mid-right, bottom-mid, bottom-right
			acc = win[0] + win[3] + win[1] - mid - win[5] - px;
			if (cfg_dir) acc = 8'd0 - acc;
			res.edge_value = acc;
			res.out_row    = ROW_W'(r - 1);
			res.out_col    = OCOL_W'(c - 1);
			res.frame_done = (r == h - 1 && c == w - 1);
		end
		upper_line[c]  = mid;
		middle_line[c] = px;
		if (col_hits[c] != 2'd2) col_hits[c] = col_hits[c] + 2'd1;
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = top;
		win[4] = mid;
		win[5] = px;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
		return hit;
	endfunction

	task automatic hold_until_drained();
		pix_if.valid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
		hold_until_drained();
		// last pixel may cause no result but still be in flight
		repeat (SETTLE_GAP) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width  = data;
			REG_IMAGE_HEIGHT: cfg_height = data;
			REG_DIRECTION:    cfg_dir    = data[0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs, input bit typed,
		input result_t want);
		result_t predicted;
		bit      hit;
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.pixel       <= px;
		pix_if.frame_start <= fs;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		hit = diag_kernel_step(px, fs, predicted);
		if (hit)
			pending_edges.push_back(typed ? want : predicted);
		else if (typed)
			log_mismatch("directed row is expected to cause a result but cannot");
		sent_count++;
	endtask

	task automatic push_pix(input logic [PIX_W-1:0] px, input logic fs);
		send_pixel(px, fs, 1'b0, '0);
		// now and then let the pipe run dry mid-frame
		if (sent_count % 300 == 150) begin
			hold_until_drained();
			@(posedge clk);
		end
	endtask

	function automatic logic [PIX_W-1:0] rand_pix();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_cfg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
		script_row_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.data   = data;
		script.push_back(s);
	endtask

	// one 3x3 frame, raster order; the last pixel gives the single interior result
	task automatic add_frame(input logic [9*PIX_W-1:0] pix9, input logic fs,
		input logic [PIX_W-1:0] want_value);
		script_row_t s;
		for (int i = 0; i < 9; i++) begin
			s = '{default: '0};
			s.px = pix9[9*PIX_W-1-PIX_W*i -: PIX_W];
			s.fs = fs && (i == 0);
			if (i == 8) begin
				s.typed           = 1'b1;
				s.want.edge_value = want_value;
				s.want.out_row    = 12'd1;
				s.want.out_col    = 11'd1;
				s.want.frame_done = 1'b1;
			end
			script.push_back(s);
		end
	endtask

	task automatic stream_phase(input int n_items, input bit start_fs);
		int frame_len;
		int stop_at;
		int cut;
		bit need_fs;
		frame_len = used_width() * used_height();
		stop_at = sent_count + n_items;
		need_fs = start_fs;
		if (!start_fs) begin
			// carry on from where the last setting left the position
			cut = $urandom_range(1, frame_len);
			for (int k = 0; k < cut; k++) push_pix(rand_pix(), 1'b0);
		end
		while (sent_count < stop_at) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					cut = $urandom_range(1, frame_len - 1);
					for (int k = 0; k < cut; k++) push_pix(rand_pix(), k == 0);
				end
				9: begin
					cut = $urandom_range(1, 12);
					for (int k = 0; k < cut; k++) begin
						push_pix(rand_pix(), need_fs || $urandom_range(0, 3) == 0);
						need_fs = 1'b0;
					end
				end
				default:
					for (int k = 0; k < frame_len; k++) push_pix(rand_pix(), k == 0);
			endcase
			need_fs = 1'b0;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_edges.size() == 0) begin
			log_mismatch($sformatf("result beat with nothing pending: row %0d col %0d",
				got.out_row, got.out_col));
			return;
		end
		want = pending_edges.pop_front();
		if (got.edge_value !== want.edge_value)
			log_mismatch($sformatf("edge_value %0h, want %0h (row %0d col %0d)",
				got.edge_value, want.edge_value, want.out_row, want.out_col));
		if (got.out_row !== want.out_row)
			log_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
		if (got.out_col !== want.out_col)
			log_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
		if (got.frame_done !== want.frame_done)
			log_mismatch($sformatf("frame_done %0b, want %0b (row %0d col %0d)",
				got.frame_done, want.frame_done, want.out_row, want.out_col));
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
			check_result('{res_if.edge_value, res_if.out_row, res_if.out_col,
				res_if.frame_done});
	end

	// result side backpressure
	initial begin
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (snk_idle_on && $urandom_range(0, 6) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		logic [REG_DATA_W-1:0] w_raw;
		logic [REG_DATA_W-1:0] h_raw;
		int                    rand_start;
		bit                    start_fs;
		arst_n             <= 1'b0;
		wr_en              <= 1'b0;
		wr_index           <= REG_IMAGE_WIDTH;
		wr_data            <= '0;
		pix_if.valid       <= 1'b0;
		pix_if.pixel       <= '0;
		pix_if.frame_start <= 1'b0;
		err_count   = 0;
		sent_count  = 0;
		cycle_count = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		cfg_width   = WIDTH_RESET;
		cfg_height  = HEIGHT_RESET;
		cfg_dir     = 1'b0;
		row_pos     = 0;
		col_pos     = 0;
		for (int i = 0; i < MAX_W; i++) begin
			upper_line[i]  = '0;
			middle_line[i] = '0;
			col_hits[i]    = '0;
		end
		for (int i = 0; i < 6; i++) win[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sizes below the minimum, kernel extremes, wrap past frame end, both kernels
		add_cfg(REG_IMAGE_WIDTH, 12'd0);
		add_cfg(REG_IMAGE_HEIGHT, 12'd0);
		// positive taps at 255: 765 wraps to fd
		add_frame({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'hFD);
		add_cfg(REG_UNUSED, 12'hFFF);
		// no frame start: position wraps on its own; negative taps give -765
		add_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF}, 1'b0, 8'h03);
		add_cfg(REG_DIRECTION, 12'd1);
		add_frame({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h03);
		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_reg(script[i].idx, script[i].data);
			else
				send_pixel(script[i].px, script[i].fs, script[i].typed, script[i].want);
		end

		// random frames over many small settings
		rand_start = sent_count;
		while (sent_count - rand_start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       w_raw = REG_DATA_W'($urandom_range(0, 2));
				1:       w_raw = REG_DATA_W'($urandom_range(13, 40));
				default: w_raw = REG_DATA_W'($urandom_range(3, 12));
			endcase
			if ($urandom_range(0, 9) == 0) h_raw = REG_DATA_W'($urandom_range(0, 2));
			else h_raw = REG_DATA_W'($urandom_range(3, 9));
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			write_reg(REG_IMAGE_WIDTH, w_raw);
			write_reg(REG_IMAGE_HEIGHT, h_raw);
			write_reg(REG_DIRECTION, REG_DATA_W'($urandom_range(0, 1)));
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_UNUSED, REG_DATA_W'($urandom_range(0, 4095)));
			// skip the frame start only if no unwritten line store entry can be read
			start_fs = !(all_defined(used_width()) && $urandom_range(0, 2) == 0);
			stream_phase($urandom_range(30, 120), start_fs);
		end

		// widest row setting, first part of the top row
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		write_reg(REG_IMAGE_WIDTH, 12'hFFF);
		write_reg(REG_IMAGE_HEIGHT, 12'd3);
		write_reg(REG_DIRECTION, REG_DATA_W'($urandom_range(0, 1)));
		for (int k = 0; k < WIDE_ITEMS; k++) push_pix(rand_pix(), k == 0);

		// tallest frame, top part only, no idling
		write_reg(REG_IMAGE_WIDTH, 12'd4);
		write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
		write_reg(REG_DIRECTION, 12'd1);
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		for (int k = 0; k < 240; k++) push_pix(rand_pix(), k == 0);

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_edges.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
